### rtl/core/mesh_cell_measure_core_defines.svh
// Assertion macros used by the core's RTL file mesh_cell_measure_core.sv
`ifndef MESH_CELL_MEASURE_CORE_DEFINES_SVH
`define MESH_CELL_MEASURE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define MCM_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define MCM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/mcm_pkg.sv
package mcm_pkg;

    localparam int CoordBits   = 20;
    localparam int VertexBits  = 3 * CoordBits;
    localparam int MaxVertices = 8;
    localparam int VAddrBits   = $clog2(MaxVertices);
    localparam int CntBits     = VAddrBits + 1;
    localparam int MulABits    = CoordBits + 1;
    localparam int MulBBits    = CoordBits + 2;
    localparam int ProdBits    = MulABits + MulBBits;
    localparam int DiffBits    = 2 * CoordBits + 1;
    localparam int SplitBits   = DiffBits - CoordBits;
    localparam int TermBits    = 61;
    localparam int AccBits     = 68;
    localparam int MeasureBits = 63;
    localparam int ShiftArea   = 9;
    localparam int StepBits    = 5;
    localparam int PhaseBits   = 5;
    localparam int DivCntBits  = 2;
    localparam int RemBits     = 2;
    localparam int DigitBits   = 17;
    localparam int CurBits     = RemBits + DigitBits;
    localparam int RecipShift  = 20;
    localparam int RecipBits   = RecipShift + DigitBits;

    // Divide by twelve as a shift by two then a division by three; six as one then three
    localparam logic [1:0]            ShiftVolume  = 2'd2;
    localparam logic [1:0]            ShiftPyramid = 2'd1;
    // ceil(2^20 / 3): exact quotient by three for any digit with a remainder below three
    localparam logic [CurBits-1:0]    Recip3     = 19'd349526;
    localparam logic [DivCntBits-1:0] DivLast    = DivCntBits'(AccBits / DigitBits - 1);
    localparam logic [MeasureBits-1:0] MeasureMax = {MeasureBits{1'b1}};
    localparam logic [1:0]            Dim2       = 2'd2;
    localparam logic [1:0]            Dim3       = 2'd3;

    typedef enum logic [1:0] {OP_ADD, OP_ADD2, OP_SUB, OP_CROSS} op_t;

    typedef enum logic [2:0] {MD_TRI2, MD_QUAD2, MD_TET, MD_PYR, MD_PRISM, MD_HEX} mode_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_TRIPLE, ST_APPLY, ST_MAG, ST_FOLD, ST_POST, ST_DIV, ST_OUT
    } state_t;

    typedef struct packed {
        logic [VAddrBits-1:0] a;
        logic [VAddrBits-1:0] b;
        logic [VAddrBits-1:0] c;
        op_t                  op;
        logic                 fold;
        logic                 last;
    } prog_t;

    function automatic prog_t mk(input logic [2:0] a, input logic [2:0] b,
                                 input logic [2:0] c, input op_t op,
                                 input logic fold, input logic last);
        prog_t p;
        p.a    = a;
        p.b    = b;
        p.c    = c;
        p.op   = op;
        p.fold = fold;
        p.last = last;
        return p;
    endfunction

    // One of the four triangulation products of a quad face
    function automatic prog_t quad_entry(input logic [2:0] v0, input logic [2:0] v1,
                                         input logic [2:0] v2, input logic [2:0] v3,
                                         input logic [1:0] pat);
        prog_t p;
        unique case (pat)
            2'd0: p = mk(v0, v1, v2, OP_ADD, 1'b0, 1'b0);
            2'd1: p = mk(v0, v2, v3, OP_ADD, 1'b0, 1'b0);
            2'd2: p = mk(v0, v1, v3, OP_ADD, 1'b0, 1'b0);
            default: p = mk(v1, v2, v3, OP_ADD, 1'b0, 1'b0);
        endcase
        return p;
    endfunction

    function automatic logic [2:0] hex_face(input logic [2:0] f, input logic [1:0] pos);
        logic [11:0] fv;
        unique case (f)
            3'd0: fv = {3'd0, 3'd1, 3'd2, 3'd3};
            3'd1: fv = {3'd0, 3'd4, 3'd5, 3'd1};
            3'd2: fv = {3'd1, 3'd5, 3'd6, 3'd2};
            3'd3: fv = {3'd2, 3'd6, 3'd7, 3'd3};
            3'd4: fv = {3'd0, 3'd3, 3'd7, 3'd4};
            default: fv = {3'd4, 3'd7, 3'd6, 3'd5};
        endcase
        unique case (pos)
            2'd0: return fv[11:9];
            2'd1: return fv[8:6];
            2'd2: return fv[5:3];
            default: return fv[2:0];
        endcase
    endfunction

    // Sequencer program: one triple product per step
    function automatic prog_t prog(input mode_t mode, input logic [StepBits-1:0] step);
        prog_t p;
        logic [StepBits-1:0] sm1;
        logic [2:0] f;
        p   = mk(3'd0, 3'd1, 3'd2, OP_ADD, 1'b1, 1'b1);
        sm1 = step - 5'd1;
        f   = step[4:2];
        unique case (mode)
            MD_TRI2: p = mk(3'd0, 3'd1, 3'd2, OP_ADD, 1'b1, 1'b1);
            MD_QUAD2:
                unique case (step)
                    5'd0: p = mk(3'd0, 3'd1, 3'd2, OP_CROSS, 1'b0, 1'b0);
                    5'd1: p = mk(3'd0, 3'd1, 3'd3, OP_CROSS, 1'b0, 1'b0);
                    default: p = mk(3'd0, 3'd2, 3'd3, OP_CROSS, 1'b0, 1'b1);
                endcase
            MD_TET:
                unique case (step)
                    5'd0: p = mk(3'd0, 3'd1, 3'd2, OP_ADD2, 1'b0, 1'b0);
                    5'd1: p = mk(3'd0, 3'd3, 3'd1, OP_ADD2, 1'b0, 1'b0);
                    5'd2: p = mk(3'd1, 3'd3, 3'd2, OP_ADD2, 1'b0, 1'b0);
                    default: p = mk(3'd0, 3'd2, 3'd3, OP_ADD2, 1'b1, 1'b1);
                endcase
            MD_PYR:
                unique case (step)
                    5'd0: p = mk(3'd1, 3'd2, 3'd4, OP_ADD, 1'b0, 1'b0);
                    5'd1: p = mk(3'd0, 3'd2, 3'd4, OP_SUB, 1'b0, 1'b0);
                    5'd2: p = mk(3'd0, 3'd1, 3'd4, OP_ADD, 1'b0, 1'b0);
                    5'd3: p = mk(3'd0, 3'd1, 3'd2, OP_SUB, 1'b1, 1'b0);
                    5'd4: p = mk(3'd2, 3'd3, 3'd4, OP_ADD, 1'b0, 1'b0);
                    5'd5: p = mk(3'd0, 3'd3, 3'd4, OP_SUB, 1'b0, 1'b0);
                    5'd6: p = mk(3'd0, 3'd2, 3'd4, OP_ADD, 1'b0, 1'b0);
                    default: p = mk(3'd0, 3'd2, 3'd3, OP_SUB, 1'b1, 1'b1);
                endcase
            MD_PRISM:
                priority if (step == 5'd0)
                    p = mk(3'd0, 3'd1, 3'd2, OP_ADD2, 1'b0, 1'b0);
                else if (step >= 5'd13)
                    p = mk(3'd3, 3'd5, 3'd4, OP_ADD2, 1'b1, 1'b1);
                else if (sm1[3:2] == 2'd0)
                    p = quad_entry(3'd0, 3'd3, 3'd4, 3'd1, sm1[1:0]);
                else if (sm1[3:2] == 2'd1)
                    p = quad_entry(3'd1, 3'd4, 3'd5, 3'd2, sm1[1:0]);
                else
                    p = quad_entry(3'd0, 3'd2, 3'd5, 3'd3, sm1[1:0]);
            MD_HEX: begin
                p = quad_entry(hex_face(f, 2'd0), hex_face(f, 2'd1),
                               hex_face(f, 2'd2), hex_face(f, 2'd3), step[1:0]);
                if (step >= 5'd23)
                begin
                    p.fold = 1'b1;
                    p.last = 1'b1;
                end
            end
            default: p = mk(3'd0, 3'd1, 3'd2, OP_ADD, 1'b1, 1'b1);
        endcase
        return p;
    endfunction

endpackage

### rtl/core/mcm_ram.sv
module mcm_ram #(
    parameter int Width = 60,
    parameter int Depth = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/mesh_cell_measure_core.sv
// A vertex without the last mark is taken and gives no result. A last vertex starts the cell:
// one triple product per sequencer step (2D triangle 1, quad 3, tetrahedron 4, pyramid 8,
// prism 14, hexahedron 24), a magnitude fold after some of them (none for the quad, two for
// the pyramid, else one) and post processing; 3D cells add the division by three and an
// output state before the result strobe. An unsupported cell is answered in the next cycle.
// Throughput: one cell at a time; reset clears the vertex counter, sets dimension 3.
`include "mesh_cell_measure_core_defines.svh"

module mesh_cell_measure_core
    import mcm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [CoordBits-1:0]   coord_x,
    input  logic signed [CoordBits-1:0]   coord_y,
    input  logic signed [CoordBits-1:0]   coord_z,
    input  logic [3:0]                    vertex_count,
    input  logic                          last_vertex,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_wdata,
    output logic                          done,
    output logic [MeasureBits-1:0]        cell_measure,
    output logic                          status
);

    // Control state
    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [PhaseBits-1:0] ph_reg, ph_next;
    logic [StepBits-1:0]  step_reg, step_next;
    logic [CntBits-1:0]   vcnt_reg, vcnt_next;
    logic [1:0]           dim_reg;
    logic [DivCntBits-1:0] dcnt_reg, dcnt_next;
    logic                 done_reg, done_next;

    // Datapath
    logic signed [CoordBits-1:0] p_reg [3], p_next [3];
    logic signed [CoordBits-1:0] s_reg [3], s_next [3];
    logic signed [CoordBits-1:0] t_reg [3], t_next [3];
    logic signed [ProdBits-1:0]  prod_reg, prod_next;
    logic signed [DiffBits-1:0]  d_reg [3], d_next [3];
    logic signed [TermBits-1:0]  term_reg, term_next;
    logic signed [TermBits-1:0]  cross_reg [3], cross_next [3];
    logic signed [AccBits-1:0]   acc_reg, acc_next;
    logic [AccBits-1:0]          mag_reg, mag_next;
    logic [AccBits-1:0]          tot_reg, tot_next;
    logic [AccBits-1:0]          dq_reg, dq_next;
    logic [RemBits-1:0]          rem_reg, rem_next;
    logic [1:0]                  div_reg, div_next;
    logic [MeasureBits-1:0]      measure_reg, measure_next;
    logic                        status_reg, status_next;

    // Vertex store
    logic                    ram_we;
    logic [VAddrBits-1:0]    ram_raddr;
    logic [VertexBits-1:0]   ram_rdata;
    logic signed [CoordBits-1:0] rd_v [3];

    logic                    accept;
    logic                    is_2d;
    prog_t                   cur;
    logic signed [MulABits-1:0] mul_a;
    logic signed [MulBBits-1:0] mul_b;
    logic signed [TermBits-1:0] prod_term;
    logic signed [AccBits-1:0]  term_ext;
    logic [TermBits:0]          abs_c [3];
    logic                       pick_a, pick_b;
    logic [CurBits-1:0]         div_cur;
    logic [RecipBits-1:0]       div_prod;
    logic [DigitBits-1:0]       div_q;
    logic [CurBits-1:0]         div_q3;

    function automatic logic same_side(input logic signed [TermBits-1:0] u,
                                       input logic signed [TermBits-1:0] v);
        return ((u > 0) && (v > 0)) || ((u < 0) && (v < 0));
    endfunction

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign ram_we = accept && !vcnt_reg[CntBits-1];
    assign is_2d  = (mode_reg == MD_TRI2) || (mode_reg == MD_QUAD2);
    assign cur    = prog(mode_reg, step_reg);

    // Issue vertex a, then b, then c on the read port
    always_comb
    begin
        priority if (ph_reg == 5'd0)
            ram_raddr = cur.a;
        else if (ph_reg == 5'd1)
            ram_raddr = cur.b;
        else
            ram_raddr = cur.c;
    end

    mcm_ram #(
        .Width (VertexBits),
        .Depth (MaxVertices)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vcnt_reg[VAddrBits-1:0]),
        .wdata ({coord_z, coord_y, coord_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Planar cells take z as integer one, so a triple product becomes the 2D determinant
    assign rd_v[0] = ram_rdata[CoordBits-1:0];
    assign rd_v[1] = ram_rdata[2*CoordBits-1:CoordBits];
    assign rd_v[2] = is_2d ? CoordBits'(1) : ram_rdata[3*CoordBits-1:2*CoordBits];

    // Shared multiplier operand schedule; the upper half of a difference is signed
    always_comb
    begin
        mul_a = MulABits'(s_reg[1]);
        mul_b = MulBBits'(t_reg[2]);
        unique case (ph_reg)
            5'd4:  begin mul_a = MulABits'(s_reg[1]); mul_b = MulBBits'(t_reg[2]); end
            5'd5:  begin mul_a = MulABits'(s_reg[2]); mul_b = MulBBits'(t_reg[1]); end
            5'd6:  begin mul_a = MulABits'(s_reg[2]); mul_b = MulBBits'(t_reg[0]); end
            5'd7:  begin mul_a = MulABits'(s_reg[0]); mul_b = MulBBits'(t_reg[2]); end
            5'd8:  begin mul_a = MulABits'(s_reg[0]); mul_b = MulBBits'(t_reg[1]); end
            5'd9:  begin mul_a = MulABits'(s_reg[1]); mul_b = MulBBits'(t_reg[0]); end
            5'd10: begin mul_a = MulABits'(p_reg[0]); mul_b = {1'b0, d_reg[0][SplitBits-1:0]}; end
            5'd11: begin
                mul_a = MulABits'(p_reg[0]);
                mul_b = MulBBits'($signed(d_reg[0][DiffBits-1:SplitBits]));
            end
            5'd12: begin mul_a = MulABits'(p_reg[1]); mul_b = {1'b0, d_reg[1][SplitBits-1:0]}; end
            5'd13: begin
                mul_a = MulABits'(p_reg[1]);
                mul_b = MulBBits'($signed(d_reg[1][DiffBits-1:SplitBits]));
            end
            5'd14: begin mul_a = MulABits'(p_reg[2]); mul_b = {1'b0, d_reg[2][SplitBits-1:0]}; end
            5'd15: begin
                mul_a = MulABits'(p_reg[2]);
                mul_b = MulBBits'($signed(d_reg[2][DiffBits-1:SplitBits]));
            end
            default: ;
        endcase
    end

    assign prod_term = TermBits'(prod_reg);
    assign term_ext  = AccBits'(term_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_c[i] = (cross_reg[i] < 0) ? (TermBits + 1)'(-(TermBits + 1)'(cross_reg[i]))
                                          : (TermBits + 1)'(cross_reg[i]);
        end
    end

    assign pick_a = same_side(cross_reg[0], cross_reg[1]) && same_side(cross_reg[2], cross_reg[1]);
    assign pick_b = same_side(cross_reg[0], cross_reg[1]);

    // Division by three, one digit a cycle: quotient digit by reciprocal multiplication
    assign div_cur  = {rem_reg, dq_reg[AccBits-1 -: DigitBits]};
    assign div_prod = RecipBits'(div_cur) * RecipBits'(Recip3);
    assign div_q    = div_prod[RecipShift +: DigitBits];
    assign div_q3   = CurBits'({div_q, 1'b0}) + CurBits'(div_q);

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        ph_next      = ph_reg;
        step_next    = step_reg;
        vcnt_next    = vcnt_reg;
        dcnt_next    = dcnt_reg;
        done_next    = 1'b0;
        prod_next    = prod_reg;
        term_next    = term_reg;
        acc_next     = acc_reg;
        mag_next     = mag_reg;
        tot_next     = tot_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        measure_next = measure_reg;
        status_next  = status_reg;
        for (int i = 0; i < 3; i++)
        begin
            p_next[i]     = p_reg[i];
            s_next[i]     = s_reg[i];
            t_next[i]     = t_reg[i];
            d_next[i]     = d_reg[i];
            cross_next[i] = cross_reg[i];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept)
                begin
                    if (!last_vertex)
                    begin
                        if (!vcnt_reg[CntBits-1])
                        begin
                            vcnt_next = vcnt_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        vcnt_next = '0;
                        ph_next   = '0;
                        step_next = '0;
                        acc_next  = '0;
                        tot_next  = '0;
                        state_next = ST_TRIPLE;
                        div_next  = ShiftVolume;
                        priority if (dim_reg == Dim2 && vertex_count == 4'd3)
                            mode_next = MD_TRI2;
                        else if (dim_reg == Dim2 && vertex_count == 4'd4)
                            mode_next = MD_QUAD2;
                        else if (dim_reg == Dim3 && vertex_count == 4'd4)
                            mode_next = MD_TET;
                        else if (dim_reg == Dim3 && vertex_count == 4'd5)
                        begin
                            mode_next = MD_PYR;
                            div_next  = ShiftPyramid;
                        end
                        else if (dim_reg == Dim3 && vertex_count == 4'd6)
                            mode_next = MD_PRISM;
                        else if (dim_reg == Dim3 && vertex_count == 4'd8)
                            mode_next = MD_HEX;
                        else
                        begin
                            // Unsupported cell: answer at once with the error status
                            state_next   = ST_IDLE;
                            done_next    = 1'b1;
                            measure_next = '0;
                            status_next  = 1'b1;
                        end
                    end
                end
            end

            ST_TRIPLE: begin
                ph_next   = ph_reg + 5'd1;
                prod_next = mul_a * mul_b;
                unique case (ph_reg)
                    5'd1:  for (int i = 0; i < 3; i++) p_next[i] = rd_v[i];
                    5'd2:  for (int i = 0; i < 3; i++) s_next[i] = rd_v[i];
                    5'd3:  for (int i = 0; i < 3; i++) t_next[i] = rd_v[i];
                    5'd5:  d_next[0] = prod_reg[DiffBits-1:0];
                    5'd6:  d_next[0] = d_reg[0] - prod_reg[DiffBits-1:0];
                    5'd7:  d_next[1] = prod_reg[DiffBits-1:0];
                    5'd8:  d_next[1] = d_reg[1] - prod_reg[DiffBits-1:0];
                    5'd9:  d_next[2] = prod_reg[DiffBits-1:0];
                    5'd10: d_next[2] = d_reg[2] - prod_reg[DiffBits-1:0];
                    5'd11: term_next = prod_term;
                    5'd12: term_next = term_reg + (prod_term <<< SplitBits);
                    5'd13: term_next = term_reg + prod_term;
                    5'd14: term_next = term_reg + (prod_term <<< SplitBits);
                    5'd15: term_next = term_reg + prod_term;
                    5'd16: begin
                        term_next  = term_reg + (prod_term <<< SplitBits);
                        state_next = ST_APPLY;
                    end
                    default: ;
                endcase
            end

            ST_APPLY: begin
                unique case (cur.op)
                    OP_ADD:   acc_next = acc_reg + term_ext;
                    OP_ADD2:  acc_next = acc_reg + (term_ext <<< 1);
                    OP_SUB:   acc_next = acc_reg - term_ext;
                    OP_CROSS: cross_next[step_reg[1:0]] = term_reg;
                    default: ;
                endcase
                priority if (cur.fold)
                    state_next = ST_MAG;
                else if (cur.last)
                    state_next = ST_POST;
                else
                begin
                    step_next  = step_reg + 5'd1;
                    ph_next    = '0;
                    state_next = ST_TRIPLE;
                end
            end

            ST_MAG: begin
                mag_next   = (acc_reg < 0) ? AccBits'(-acc_reg) : AccBits'(acc_reg);
                acc_next   = '0;
                state_next = ST_FOLD;
            end

            ST_FOLD: begin
                tot_next = tot_reg + mag_reg;
                if (cur.last)
                    state_next = ST_POST;
                else
                begin
                    step_next  = step_reg + 5'd1;
                    ph_next    = '0;
                    state_next = ST_TRIPLE;
                end
            end

            ST_POST: begin
                unique case (mode_reg)
                    MD_TRI2: begin
                        measure_next = MeasureBits'(tot_reg) << ShiftArea;
                        status_next  = 1'b0;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    MD_QUAD2: begin
                        priority if (pick_a)
                            measure_next = MeasureBits'(abs_c[0] + abs_c[2]) << ShiftArea;
                        else if (pick_b)
                            measure_next = MeasureBits'(abs_c[1] + abs_c[2]) << ShiftArea;
                        else
                            measure_next = MeasureBits'(abs_c[0] + abs_c[1]) << ShiftArea;
                        status_next = 1'b0;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    default: begin
                        // Take off the power-of-two part of the divisor, leave three
                        dq_next    = tot_reg >> div_reg;
                        rem_next   = '0;
                        dcnt_next  = '0;
                        state_next = ST_DIV;
                    end
                endcase
            end

            ST_DIV: begin
                // Advance one quotient digit, keep the remainder for the next
                rem_next  = RemBits'(div_cur - div_q3);
                dq_next   = {dq_reg[AccBits-DigitBits-1:0], div_q};
                dcnt_next = dcnt_reg + 2'd1;
                if (dcnt_reg == DivLast)
                    state_next = ST_OUT;
            end

            ST_OUT: begin
                // Saturate the quotient to the result width
                measure_next = (|dq_reg[AccBits-1:MeasureBits]) ? MeasureMax
                                                                : dq_reg[MeasureBits-1:0];
                status_next  = 1'b0;
                done_next    = 1'b1;
                state_next   = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MD_TET;
            ph_reg    <= '0;
            step_reg  <= '0;
            vcnt_reg  <= '0;
            dim_reg   <= Dim3;
            dcnt_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            ph_reg    <= ph_next;
            step_reg  <= step_next;
            vcnt_reg  <= vcnt_next;
            dcnt_reg  <= dcnt_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                dim_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        term_reg    <= term_next;
        acc_reg     <= acc_next;
        mag_reg     <= mag_next;
        tot_reg     <= tot_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        measure_reg <= measure_next;
        status_reg  <= status_next;
        for (int i = 0; i < 3; i++)
        begin
            p_reg[i]     <= p_next[i];
            s_reg[i]     <= s_next[i];
            t_reg[i]     <= t_next[i];
            d_reg[i]     <= d_next[i];
            cross_reg[i] <= cross_next[i];
        end
    end

    assign done         = done_reg;
    assign cell_measure = measure_reg;
    assign status       = status_reg;

    // Checks
    `MCM_ASSERT_NOW(a_done_idle, done_reg, !busy, "result strobe while busy")
    `MCM_ASSERT_NOW(a_err_zero, done_reg && status_reg, measure_reg == '0,
        "error transaction with non-zero measure")
    `MCM_ASSERT_NOW(a_rise_cnt, $rose(busy), vcnt_reg == '0,
        "vertex counter not cleared at cell start")
    `MCM_ASSERT_NEXT(a_last_resp, accept && last_vertex, busy || done_reg,
        "last vertex neither started nor answered")
    `MCM_ASSERT_NOW(a_div_solid, state_reg == ST_DIV,
        mode_reg != MD_TRI2 && mode_reg != MD_QUAD2, "division in a planar cell")

endmodule

### tb/mesh_cell_measure_core_tb.sv
`timescale 1ns / 100ps

module mesh_cell_measure_core_tb;
    import mcm_pkg::*;

    localparam logic [62:0] MEAS_SAT = {63{1'b1}};

    // Face tables of the solid cells: tetrahedron, prism, hexahedron
    localparam int FACE_LEN [3][6] = '{'{3, 3, 3, 3, 0, 0},
                                       '{3, 4, 4, 4, 3, 0},
                                       '{4, 4, 4, 4, 4, 4}};
    localparam int FACE_VTX [3][6][4] = '{
        '{'{0,1,2,0}, '{0,3,1,0}, '{1,3,2,0}, '{0,2,3,0}, '{0,0,0,0}, '{0,0,0,0}},
        '{'{0,1,2,0}, '{0,3,4,1}, '{1,4,5,2}, '{0,2,5,3}, '{3,5,4,0}, '{0,0,0,0}},
        '{'{0,1,2,3}, '{0,4,5,1}, '{1,5,6,2}, '{2,6,7,3}, '{0,3,7,4}, '{4,7,6,5}}};

    typedef struct {
        logic [62:0] measure;
        logic        bad_count;
    } cell_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
    logic [3:0]                  vertex_count;
    logic                        last_vertex;
    logic                        cfg_we;
    logic [1:0]                  cfg_wdata;
    logic                        done;
    logic [MeasureBits-1:0]      cell_measure;
    logic                        status;

    // Shadow of the block: stored vertices, write slot and dimension
    logic signed [63:0] shadow_vtx [8][3];
    int unsigned        shadow_slot;
    logic [1:0]         shadow_dim;

    cell_result_t pending_cells [$];
    int unsigned  error_count;
    int unsigned  items_sent;
    int unsigned  idle_pct;

    mesh_cell_measure_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .vertex_count (vertex_count),
        .last_vertex  (last_vertex),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .cell_measure (cell_measure),
        .status       (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Geometry of the shadow store, all held wide enough to be exact
    // ---------------------------------------------------------------
    function automatic logic signed [127:0] triple_prod(int a, int b, int c);
        logic signed [127:0] r;
        r = shadow_vtx[a][0] * (shadow_vtx[b][1] * shadow_vtx[c][2]
                                - shadow_vtx[b][2] * shadow_vtx[c][1])
          + shadow_vtx[a][1] * (shadow_vtx[b][2] * shadow_vtx[c][0]
                                - shadow_vtx[b][0] * shadow_vtx[c][2])
          + shadow_vtx[a][2] * (shadow_vtx[b][0] * shadow_vtx[c][1]
                                - shadow_vtx[b][1] * shadow_vtx[c][0]);
        return r;
    endfunction

    // Twice the triangle area by the shoelace sum, as a magnitude
    function automatic logic signed [127:0] twice_tri_area(int a, int b, int c);
        logic signed [127:0] v;
        v = (shadow_vtx[a][0] - shadow_vtx[b][0]) * (shadow_vtx[a][1] + shadow_vtx[b][1])
          + (shadow_vtx[b][0] - shadow_vtx[c][0]) * (shadow_vtx[b][1] + shadow_vtx[c][1])
          + (shadow_vtx[c][0] - shadow_vtx[a][0]) * (shadow_vtx[c][1] + shadow_vtx[a][1]);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [127:0] cross_2d(int o, int a, int b);
        return (shadow_vtx[a][0] - shadow_vtx[o][0]) * (shadow_vtx[b][1] - shadow_vtx[o][1])
             - (shadow_vtx[a][1] - shadow_vtx[o][1]) * (shadow_vtx[b][0] - shadow_vtx[o][0]);
    endfunction

    // A zero cross product is never on the same side
    function automatic bit same_side(logic signed [127:0] u, logic signed [127:0] v);
        return (u > 0 && v > 0) || (u < 0 && v < 0);
    endfunction

    function automatic logic [62:0] div_saturate(logic signed [127:0] mag, int divisor);
        logic signed [127:0] q;
        q = mag / divisor;
        return (q > $signed({65'd0, MEAS_SAT})) ? MEAS_SAT : q[62:0];
    endfunction

    function automatic logic signed [127:0] abs_wide(logic signed [127:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [62:0] solid_volume(int kind);
        logic signed [127:0] acc;
        acc = 0;
        for (int f = 0; f < 6; f++)
        begin
            if (FACE_LEN[kind][f] == 3)
                acc += 2 * triple_prod(FACE_VTX[kind][f][0], FACE_VTX[kind][f][1],
                                       FACE_VTX[kind][f][2]);
            else if (FACE_LEN[kind][f] == 4)
                // sum of the two triangulations of the quad face, twice their mean
                acc += triple_prod(FACE_VTX[kind][f][0], FACE_VTX[kind][f][1],
                                   FACE_VTX[kind][f][2])
                     + triple_prod(FACE_VTX[kind][f][0], FACE_VTX[kind][f][2],
                                   FACE_VTX[kind][f][3])
                     + triple_prod(FACE_VTX[kind][f][0], FACE_VTX[kind][f][1],
                                   FACE_VTX[kind][f][3])
                     + triple_prod(FACE_VTX[kind][f][1], FACE_VTX[kind][f][2],
                                   FACE_VTX[kind][f][3]);
        end
        return div_saturate(abs_wide(acc), 12);
    endfunction

    function automatic logic signed [127:0] tet_volume6(int a, int b, int c, int e);
        return abs_wide(triple_prod(b, c, e) - triple_prod(a, c, e)
                        + triple_prod(a, b, e) - triple_prod(a, b, c));
    endfunction

    function automatic cell_result_t measure_cell(logic [3:0] cnt);
        cell_result_t        r;
        logic signed [127:0] s;
        logic signed [127:0] c012;
        logic signed [127:0] c013;
        logic signed [127:0] c023;
        r.measure   = '0;
        r.bad_count = 1'b0;
        if (shadow_dim == Dim2 && cnt == 4'd3)
        begin
            s = twice_tri_area(0, 1, 2) <<< ShiftArea;
            r.measure = s[62:0];
        end
        else if (shadow_dim == Dim2 && cnt == 4'd4)
        begin
            c012 = cross_2d(0, 1, 2);
            c013 = cross_2d(0, 1, 3);
            c023 = cross_2d(0, 2, 3);
            if (same_side(c012, c013))
            begin
                if (same_side(c023, c013))
                    s = twice_tri_area(0, 2, 1) + twice_tri_area(0, 2, 3);
                else
                    s = twice_tri_area(0, 3, 1) + twice_tri_area(0, 3, 2);
            end
            else
                s = twice_tri_area(0, 1, 2) + twice_tri_area(0, 1, 3);
            s = s <<< ShiftArea;
            r.measure = s[62:0];
        end
        else if (shadow_dim == Dim3 && cnt == 4'd4)
            r.measure = solid_volume(0);
        else if (shadow_dim == Dim3 && cnt == 4'd5)
            r.measure = div_saturate(tet_volume6(0, 1, 2, 4) + tet_volume6(0, 2, 3, 4), 6);
        else if (shadow_dim == Dim3 && cnt == 4'd6)
            r.measure = solid_volume(1);
        else if (shadow_dim == Dim3 && cnt == 4'd8)
            r.measure = solid_volume(2);
        else
            r.bad_count = 1'b1;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Send one vertex transaction; hold it until the block takes it
    task automatic send_vertex(input logic [19:0] x, input logic [19:0] y,
                               input logic [19:0] z, input logic [3:0] cnt,
                               input logic last);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        coord_x      <= x;
        coord_y      <= y;
        coord_z      <= z;
        vertex_count <= cnt;
        last_vertex  <= last;
        start        <= 1'b1;
        do @(posedge clk); while (busy);
        // accepted at this edge: advance the shadow
        if (shadow_slot < MaxVertices)
        begin
            shadow_vtx[shadow_slot][0] = $signed(x);
            shadow_vtx[shadow_slot][1] = $signed(y);
            shadow_vtx[shadow_slot][2] = $signed(z);
            shadow_slot++;
        end
        if (last)
        begin
            shadow_slot = 0;
            pending_cells.push_back(measure_cell(cnt));
        end
        items_sent++;
    endtask

    // Drop start and wait until every expected cell has arrived
    task automatic drain_cells();
        start <= 1'b0;
        @(posedge clk);
        while (pending_cells.size() != 0) @(posedge clk);
        // a vertex without the last mark may still be settling
        repeat (8) @(posedge clk);
    endtask

    task automatic set_dimension(input logic [1:0] dim);
        drain_cells();
        cfg_we    <= 1'b1;
        cfg_wdata <= dim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_dim = dim;
        @(posedge clk);
    endtask

    function automatic logic [19:0] rand_coord(int unsigned spread);
        case (spread)
            0: return 20'(signed'($urandom_range(0, 64)) - 32);
            1: return 20'(signed'($urandom_range(0, 8191)) - 4096);
            2: return ($urandom_range(0, 1) != 0) ? 20'h7FFFF : 20'h80000;
            default: return 20'($urandom);
        endcase
    endfunction

    // One cell: mostly well formed, sometimes short, long or with a stray count
    task automatic send_random_cell();
        int unsigned        n;
        int unsigned        spread;
        logic [3:0]         cnt;
        logic [19:0]        pts [10][3];
        if (shadow_dim == Dim2)
            cnt = ($urandom_range(0, 1) != 0) ? 4'd3 : 4'd4;
        else
            case ($urandom_range(0, 3))
                0: cnt = 4'd4;
                1: cnt = 4'd5;
                2: cnt = 4'd6;
                default: cnt = 4'd8;
            endcase
        n = cnt;
        case ($urandom_range(0, 19))
            0: cnt = 4'($urandom_range(0, 15));
            1: n = $urandom_range(1, 10);
            2: n = $urandom_range(9, 10);
            default: ;
        endcase
        spread = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < 3; k++)
                pts[i][k] = rand_coord(spread);
            // repeated and collinear vertices reach the degenerate paths
            if (i > 0 && $urandom_range(0, 9) == 0)
                pts[i] = pts[i-1];
            if (i > 1 && $urandom_range(0, 9) == 0)
                for (int k = 0; k < 3; k++)
                    pts[i][k] = 20'(2 * signed'(pts[i-1][k]) - signed'(pts[i-2][k]));
        end
        for (int i = 0; i < n; i++)
            send_vertex(pts[i][0], pts[i][1], pts[i][2], cnt, i == n - 1);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Fill every slot with a cube of side 1024 first, so no slot is read unwritten
    task automatic test_reset_cube();
        for (int i = 0; i < 8; i++)
            send_vertex((i == 1 || i == 2 || i == 5 || i == 6) ? 20'd1024 : 20'd0,
                        (i == 2 || i == 3 || i == 6 || i == 7) ? 20'd1024 : 20'd0,
                        (i >= 4) ? 20'd1024 : 20'd0, 4'd8, i == 7);
    endtask

    task automatic test_planar();
        set_dimension(Dim2);
        send_vertex(20'h80000, 20'h80000, 20'h7FFFF, 4'd3, 1'b0);
        send_vertex(20'h7FFFF, 20'h80000, 20'h00000, 4'd3, 1'b0);
        send_vertex(20'h00000, 20'h7FFFF, 20'h80000, 4'd3, 1'b1);
        // quad with three collinear vertices: one zero cross product
        send_vertex(20'd0,    20'd0,    20'd5, 4'd4, 1'b0);
        send_vertex(20'd1024, 20'd1024, 20'd5, 4'd4, 1'b0);
        send_vertex(20'd2048, 20'd2048, 20'd5, 4'd4, 1'b0);
        send_vertex(20'd0,    20'd3072, 20'd5, 4'd4, 1'b1);
        // count not supported for planar cells
        send_vertex(20'd7, 20'd9, 20'd11, 4'd5, 1'b1);
    endtask

    task automatic test_solid();
        set_dimension(Dim3);
        send_vertex(20'h80000, 20'h80000, 20'h80000, 4'd4, 1'b0);
        send_vertex(20'h7FFFF, 20'h80000, 20'h80000, 4'd4, 1'b0);
        send_vertex(20'h80000, 20'h7FFFF, 20'h80000, 4'd4, 1'b0);
        send_vertex(20'h80000, 20'h80000, 20'h7FFFF, 4'd4, 1'b1);
        // pyramid and prism over stale slots, then an unsupported count
        send_vertex(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 4'd5, 1'b1);
        send_vertex(20'd100, 20'd200, 20'd300, 4'd6, 1'b1);
        send_vertex(20'd1, 20'd2, 20'd3, 4'd7, 1'b1);
    endtask

    task automatic test_bad_dimension();
        set_dimension(2'd0);
        send_vertex(20'd1, 20'd2, 20'd3, 4'd4, 1'b1);
        set_dimension(2'd1);
        send_vertex(20'd4, 20'd5, 20'd6, 4'd3, 1'b1);
    endtask

    task automatic test_random_cells(input int unsigned sender_idle, input int unsigned quota);
        int unsigned goal;
        idle_pct = sender_idle;
        goal     = items_sent + quota;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                set_dimension(($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 1))
                                                          : 2'($urandom_range(2, 3)));
            else if ($urandom_range(0, 24) == 0)
                drain_cells();
            send_random_cell();
        end
    endtask

    // ---------------------------------------------------------------
    // Result checking: every strobe must match the oldest expected cell
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        cell_result_t exp_cell;
        if (rst_n && done)
        begin
            if (pending_cells.size() == 0)
            begin
                $error("unexpected result: cell_measure %0h status %0d", cell_measure, status);
                error_count++;
            end
            else
            begin
                exp_cell = pending_cells.pop_front();
                if (cell_measure !== exp_cell.measure)
                begin
                    $error("cell_measure expected %0h actual %0h",
                           exp_cell.measure, cell_measure);
                    error_count++;
                end
                if (status !== exp_cell.bad_count)
                begin
                    $error("status expected %0d actual %0d", exp_cell.bad_count, status);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        coord_x      = '0;
        coord_y      = '0;
        coord_z      = '0;
        vertex_count = '0;
        last_vertex  = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        error_count  = 0;
        items_sent   = 0;
        idle_pct     = 0;
        shadow_slot  = 0;
        shadow_dim   = Dim3;
        for (int i = 0; i < 8; i++)
            for (int k = 0; k < 3; k++)
                shadow_vtx[i][k] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_cube();
        test_planar();
        test_solid();
        test_bad_dimension();
        set_dimension(Dim3);
        test_random_cells(18, 250);
        test_random_cells(61, 250);
        test_random_cells(0, 250);

        drain_cells();
        repeat (600) @(posedge clk);
        if (error_count == 0 && pending_cells.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/mcm_pkg.sv
rtl/core/mcm_ram.sv
rtl/core/mesh_cell_measure_core.sv
tb/mesh_cell_measure_core_tb.sv
